[rtl/rtsf_pkg.sv]
// Shared types and constants for the resistive touch sample filter.
package rtsf_pkg;

    // Input action codes
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_PEN_UP = 2'd1;
    localparam logic [1:0] ACT_ACK    = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // Group order within one reading
    localparam logic [1:0] GRP_X1 = 2'd0;
    localparam logic [1:0] GRP_Y1 = 2'd1;
    localparam logic [1:0] GRP_X2 = 2'd2;
    localparam logic [1:0] GRP_Y2 = 2'd3;

    // Register map (word index)
    localparam int         ADDR_W           = 5;
    localparam logic [2:0] REG_AGREE_RANGE  = 3'd0;
    localparam logic [2:0] REG_RAW_MODE     = 3'd1;
    localparam logic [2:0] REG_LANDSCAPE    = 3'd2;
    localparam logic [2:0] REG_SCREEN_WIDTH = 3'd3;
    localparam logic [2:0] REG_X_GAIN       = 3'd4;
    localparam logic [2:0] REG_X_OFFSET     = 3'd5;
    localparam logic [2:0] REG_Y_GAIN       = 3'd6;
    localparam logic [2:0] REG_Y_OFFSET     = 3'd7;

    localparam logic [15:0] COORD_NONE = 16'hFFFF;

    typedef struct packed {
        logic [11:0]        agree_range;
        logic               raw_mode;
        logic               landscape;
        logic [15:0]        screen_width;
        logic signed [17:0] x_gain;
        logic signed [15:0] x_offset;
        logic signed [17:0] y_gain;
        logic signed [15:0] y_offset;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT,
        ST_SUM,
        ST_MUL,
        ST_QUOT,
        ST_CHECK,
        ST_CALX,
        ST_CALY,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic store_sample;
        logic pen_up;
        logic ack;
        logic sort_step;
        logic sort_odd;
        logic sum_step;
        logic sum_take;
        logic mul;
        logic quot;
        logic check;
        logic cal_x;
        logic cal_y;
        logic update;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic group_full;
        logic last_group;
        logic out_free;
    } dp_sts_t;

endpackage

[rtl/resistive_touch_sample_filter_core.sv]
// Top level of the resistive touch sample filter: config bank, controller, datapath.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+----------------------------------------
//  s_      | in        | s_valid / s_ready      | s_action[1:0], s_sample[ADC_BITS-1:0]
//  m_      | out       | m_valid / m_ready      | m_x_coord, m_y_coord, m_reading_ok,
//          |           |                        | m_pressed, m_caught, m_start_x, m_start_y
//  APB     | in        | psel/penable/pready    | paddr[4:0], pwdata, prdata (32 bit)
//
// Sequence: a sample that does not close a group leaves the controller idle (s_ready
// stays high). Closing a group adds N sort steps of the odd-even network,
// N-DROP trim-sum steps and the divide (reciprocal multiply, then select).
// The last group of a reading adds check, two calibration multiplies, update and
// result load. Pen-up and acknowledge transactions go through the result load step.
// Any result waits in the output register; the block stalls in its load step until
// that register frees.
// Reset: aresetn is synchronous, active low; flags, coordinates and config go to
// their defaults, the group buffer and averages stay unknown until written.
module resistive_touch_sample_filter_core #(
    parameter int SAMPLES_PER_GROUP = 5,
    parameter int DROP_EACH_END     = 1,
    parameter int ADC_BITS          = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input transactions
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [ADC_BITS-1:0]          s_sample,
    // result transactions
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [15:0]                  m_x_coord,
    output logic [15:0]                  m_y_coord,
    output logic                         m_reading_ok,
    output logic                         m_pressed,
    output logic                         m_caught,
    output logic [15:0]                  m_start_x,
    output logic [15:0]                  m_start_y,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rtsf_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // Trim clamps so at least one value survives.
    localparam int DROP = (2 * DROP_EACH_END >= SAMPLES_PER_GROUP)
                          ? (SAMPLES_PER_GROUP - 1) / 2 : DROP_EACH_END;

    rtsf_pkg::cfg_t    cfg;
    rtsf_pkg::dp_cmd_t cmd;
    rtsf_pkg::dp_sts_t sts;

    rtsf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Controller sequences one transaction at a time.
    rtsf_ctrl #(
        .N    (SAMPLES_PER_GROUP),
        .DROP (DROP)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .sts      (sts),
        .s_ready  (s_ready),
        .cmd      (cmd)
    );

    rtsf_datapath #(
        .N        (SAMPLES_PER_GROUP),
        .DROP     (DROP),
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .sample       (s_sample),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_x_coord    (m_x_coord),
        .m_y_coord    (m_y_coord),
        .m_reading_ok (m_reading_ok),
        .m_pressed    (m_pressed),
        .m_caught     (m_caught),
        .m_start_x    (m_start_x),
        .m_start_y    (m_start_y),
        .sts          (sts)
    );

`ifndef SYNTHESIS
    // Pen-up / acknowledge must go to the result load step, not straight back to idle.
    a_cmd_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action == rtsf_pkg::ACT_PEN_UP ||
                               s_action == rtsf_pkg::ACT_ACK) |=> !s_ready)
        else $error("pen-up/ack transaction did not hold off input");

    // An accepted reading always leaves the pen marked as pressed.
    a_ok_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reading_ok |-> m_pressed)
        else $error("reading taken without pressed flag");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule

[rtl/rtsf_regs.sv]
// APB configuration register bank.
module rtsf_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rtsf_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output rtsf_pkg::cfg_t               cfg
);

    rtsf_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.agree_range  <= 12'd50;
            cfg_reg.raw_mode     <= 1'b0;
            cfg_reg.landscape    <= 1'b0;
            cfg_reg.screen_width <= 16'd240;
            cfg_reg.x_gain       <= 18'sd65536;
            cfg_reg.x_offset     <= 16'sd0;
            cfg_reg.y_gain       <= 18'sd65536;
            cfg_reg.y_offset     <= 16'sd0;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                rtsf_pkg::REG_AGREE_RANGE:  cfg_reg.agree_range  <= pwdata[11:0];
                rtsf_pkg::REG_RAW_MODE:     cfg_reg.raw_mode     <= pwdata[0];
                rtsf_pkg::REG_LANDSCAPE:    cfg_reg.landscape    <= pwdata[0];
                rtsf_pkg::REG_SCREEN_WIDTH: cfg_reg.screen_width <= pwdata[15:0];
                rtsf_pkg::REG_X_GAIN:       cfg_reg.x_gain       <= pwdata[17:0];
                rtsf_pkg::REG_X_OFFSET:     cfg_reg.x_offset     <= pwdata[15:0];
                rtsf_pkg::REG_Y_GAIN:       cfg_reg.y_gain       <= pwdata[17:0];
                rtsf_pkg::REG_Y_OFFSET:     cfg_reg.y_offset     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            rtsf_pkg::REG_AGREE_RANGE:  prdata = {20'd0, cfg_reg.agree_range};
            rtsf_pkg::REG_RAW_MODE:     prdata = {31'd0, cfg_reg.raw_mode};
            rtsf_pkg::REG_LANDSCAPE:    prdata = {31'd0, cfg_reg.landscape};
            rtsf_pkg::REG_SCREEN_WIDTH: prdata = {16'd0, cfg_reg.screen_width};
            rtsf_pkg::REG_X_GAIN:       prdata = {14'd0, cfg_reg.x_gain};
            rtsf_pkg::REG_X_OFFSET:     prdata = {16'd0, cfg_reg.x_offset};
            rtsf_pkg::REG_Y_GAIN:       prdata = {14'd0, cfg_reg.y_gain};
            rtsf_pkg::REG_Y_OFFSET:     prdata = {16'd0, cfg_reg.y_offset};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

[rtl/rtsf_ctrl.sv]
// Sequencing state machine: collection, sort, trim sum, divide, calibrate, emit.
module rtsf_ctrl #(
    parameter int N    = 5,
    parameter int DROP = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [1:0]          s_action,
    input  rtsf_pkg::dp_sts_t   sts,
    output logic                s_ready,
    output rtsf_pkg::dp_cmd_t   cmd
);

    localparam int CW = $clog2(N + 1);
    localparam logic [CW-1:0] SORT_LAST = CW'(N - 1);
    localparam logic [CW-1:0] SUM_LAST  = CW'(N - DROP - 1);
    localparam logic [CW-1:0] DROP_C    = CW'(DROP);

    rtsf_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    step_reg, step_next;
    logic             accept;

    assign accept = s_valid && (state_reg == rtsf_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rtsf_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            rtsf_pkg::ST_IDLE: begin
                step_next = '0;
                if (accept) begin
                    unique case (s_action)
                        rtsf_pkg::ACT_SAMPLE: begin
                            if (sts.group_full) state_next = rtsf_pkg::ST_SORT;
                        end
                        rtsf_pkg::ACT_PEN_UP: state_next = rtsf_pkg::ST_EMIT;
                        rtsf_pkg::ACT_ACK:    state_next = rtsf_pkg::ST_EMIT;
                        default: ;
                    endcase
                end
            end
            rtsf_pkg::ST_SORT: begin
                if (step_reg == SORT_LAST) begin
                    step_next  = '0;
                    state_next = rtsf_pkg::ST_SUM;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            rtsf_pkg::ST_SUM: begin
                if (step_reg == SUM_LAST) begin
                    step_next  = '0;
                    state_next = rtsf_pkg::ST_MUL;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            rtsf_pkg::ST_MUL:  state_next = rtsf_pkg::ST_QUOT;
            rtsf_pkg::ST_QUOT: begin
                state_next = sts.last_group ? rtsf_pkg::ST_CHECK : rtsf_pkg::ST_IDLE;
            end
            rtsf_pkg::ST_CHECK:  state_next = rtsf_pkg::ST_CALX;
            rtsf_pkg::ST_CALX:   state_next = rtsf_pkg::ST_CALY;
            rtsf_pkg::ST_CALY:   state_next = rtsf_pkg::ST_UPDATE;
            rtsf_pkg::ST_UPDATE: state_next = rtsf_pkg::ST_EMIT;
            rtsf_pkg::ST_EMIT: begin
                if (sts.out_free) state_next = rtsf_pkg::ST_IDLE;
            end
            default: state_next = rtsf_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            rtsf_pkg::ST_IDLE: begin
                s_ready          = 1'b1;
                cmd.store_sample = accept && (s_action == rtsf_pkg::ACT_SAMPLE);
                cmd.pen_up       = accept && (s_action == rtsf_pkg::ACT_PEN_UP);
                cmd.ack          = accept && (s_action == rtsf_pkg::ACT_ACK);
            end
            rtsf_pkg::ST_SORT: begin
                cmd.sort_step = 1'b1;
                cmd.sort_odd  = step_reg[0];
            end
            rtsf_pkg::ST_SUM: begin
                cmd.sum_step = 1'b1;
                cmd.sum_take = (step_reg >= DROP_C);
            end
            rtsf_pkg::ST_MUL:    cmd.mul    = 1'b1;
            rtsf_pkg::ST_QUOT:   cmd.quot   = 1'b1;
            rtsf_pkg::ST_CHECK:  cmd.check  = 1'b1;
            rtsf_pkg::ST_CALX:   cmd.cal_x  = 1'b1;
            rtsf_pkg::ST_CALY:   cmd.cal_y  = 1'b1;
            rtsf_pkg::ST_UPDATE: cmd.update = 1'b1;
            rtsf_pkg::ST_EMIT:   cmd.emit   = sts.out_free;
            default: ;
        endcase
    end

endmodule

[rtl/rtsf_datapath.sv]
// Datapath: group buffer, sort network step, trim sum, divider, calibration, touch state.
module rtsf_datapath #(
    parameter int N        = 5,
    parameter int DROP     = 1,
    parameter int ADC_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rtsf_pkg::cfg_t        cfg,
    input  rtsf_pkg::dp_cmd_t     cmd,
    input  logic [ADC_BITS-1:0]   sample,
    input  logic                  m_ready,
    output logic                  m_valid,
    output logic [15:0]           m_x_coord,
    output logic [15:0]           m_y_coord,
    output logic                  m_reading_ok,
    output logic                  m_pressed,
    output logic                  m_caught,
    output logic [15:0]           m_start_x,
    output logic [15:0]           m_start_y,
    output rtsf_pkg::dp_sts_t     sts
);

    localparam int POS_W   = $clog2(N);
    localparam int KEEP    = N - 2 * DROP;
    localparam int KEEP_LG = $clog2(KEEP);
    localparam int SUM_W   = ADC_BITS + KEEP_LG;
    localparam int SHIFT   = SUM_W + KEEP_LG;
    localparam int PROD_W  = SUM_W + SHIFT + 1;
    // ceil(2^SHIFT / KEEP): exact quotient for every sum below 2^SUM_W
    localparam longint RECIP = ((longint'(1) << SHIFT) + KEEP - 1) / KEEP;
    localparam logic [SHIFT:0] RECIP_C = (SHIFT + 1)'(RECIP);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(N - 1);

    logic [ADC_BITS-1:0] grp_buf_reg [N];
    logic [ADC_BITS-1:0] sorted      [N];
    logic [POS_W-1:0]    pos_reg;
    logic [1:0]          grp_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ADC_BITS-1:0] avg;
    logic [ADC_BITS-1:0] x1_avg_reg, y1_avg_reg, x2_avg_reg, y2_avg_reg;
    logic                ok_reg;
    logic [ADC_BITS-1:0] rx_reg, ry_reg;
    logic signed [34:0]  cal_prod_reg;
    logic [15:0]         cal_x_reg;
    logic [15:0]         cal_y;
    logic [15:0]         held_x_reg, held_y_reg;
    logic [15:0]         start_x_reg, start_y_reg;
    logic                pressed_reg, caught_reg;
    logic [15:0]         hx_new, hy_new;
    logic signed [16:0]  rx_s, ry_s;

    logic                m_valid_reg;
    logic [15:0]         m_x_coord_reg, m_y_coord_reg, m_start_x_reg, m_start_y_reg;
    logic                m_reading_ok_reg, m_pressed_reg, m_caught_reg;

    function automatic logic agree(input logic [ADC_BITS-1:0] a,
                                   input logic [ADC_BITS-1:0] b,
                                   input logic [11:0] range);
        logic [ADC_BITS-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return 17'(d) < 17'(range);
    endfunction

    // (prod + off*2^16) / 2^16 toward zero, clamped to 0..65535
    function automatic logic [15:0] cal_sat(input logic signed [34:0] p,
                                            input logic signed [15:0] off);
        logic signed [35:0] num;
        num = 36'(p) + (36'(off) <<< 16);
        if (num[35])            return 16'd0;
        else if (|num[34:32])   return 16'hFFFF;
        else                    return num[31:16];
    endfunction

    // odd-even transposition step
    always_comb begin
        for (int i = 0; i < N; i++) sorted[i] = grp_buf_reg[i];
        for (int i = 0; i < N - 1; i++) begin
            if ((i % 2 == 1) == cmd.sort_odd && grp_buf_reg[i] > grp_buf_reg[i + 1]) begin
                sorted[i]     = grp_buf_reg[i + 1];
                sorted[i + 1] = grp_buf_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_sample) grp_buf_reg[pos_reg] <= sample;
        else if (cmd.sort_step) begin
            for (int i = 0; i < N; i++) grp_buf_reg[i] <= sorted[i];
        end else if (cmd.sum_step) begin
            for (int i = 0; i < N - 1; i++) grp_buf_reg[i] <= grp_buf_reg[i + 1];
        end
    end

    assign avg  = prod_reg[SHIFT +: ADC_BITS];
    assign rx_s = {1'b0, 16'(rx_reg)};
    assign ry_s = {1'b0, 16'(ry_reg)};
    assign cal_y = cal_sat(cal_prod_reg, cfg.y_offset);

    // payload registers of the arithmetic chain
    always_ff @(posedge aclk) begin
        if (cmd.sort_step) sum_reg <= '0;
        if (cmd.sum_step && cmd.sum_take) sum_reg <= sum_reg + SUM_W'(grp_buf_reg[0]);
        if (cmd.mul) prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP_C);
        if (cmd.quot) begin
            case (grp_reg)
                rtsf_pkg::GRP_X1: x1_avg_reg <= avg;
                rtsf_pkg::GRP_Y1: y1_avg_reg <= avg;
                rtsf_pkg::GRP_X2: x2_avg_reg <= avg;
                default:          y2_avg_reg <= avg;
            endcase
        end
        if (cmd.check) begin
            rx_reg <= ADC_BITS'(((ADC_BITS + 1)'(x1_avg_reg) + x2_avg_reg) >> 1);
            ry_reg <= ADC_BITS'(((ADC_BITS + 1)'(y1_avg_reg) + y2_avg_reg) >> 1);
        end
        if (cmd.cal_x) cal_prod_reg <= cfg.x_gain * rx_s;
        if (cmd.cal_y) begin
            cal_x_reg    <= cal_sat(cal_prod_reg, cfg.x_offset);
            cal_prod_reg <= cfg.y_gain * ry_s;
        end
    end

    always_comb begin
        hx_new = held_x_reg;
        hy_new = held_y_reg;
        if (ok_reg) begin
            hx_new = cfg.raw_mode ? 16'(rx_reg) : cal_x_reg;
            hy_new = cfg.raw_mode ? 16'(ry_reg) : cal_y;
        end
    end

    // touch state and collection position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            grp_reg     <= rtsf_pkg::GRP_X1;
            ok_reg      <= 1'b0;
            held_x_reg  <= rtsf_pkg::COORD_NONE;
            held_y_reg  <= rtsf_pkg::COORD_NONE;
            start_x_reg <= '0;
            start_y_reg <= '0;
            pressed_reg <= 1'b0;
            caught_reg  <= 1'b0;
        end else begin
            if (cmd.store_sample) pos_reg <= (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
            if (cmd.quot) grp_reg <= grp_reg + 1'b1;
            if (cmd.check) begin
                ok_reg <= agree(x1_avg_reg, x2_avg_reg, cfg.agree_range)
                       && agree(y1_avg_reg, y2_avg_reg, cfg.agree_range);
            end
            if (cmd.pen_up) begin
                ok_reg  <= 1'b0;
                pos_reg <= '0;
                grp_reg <= rtsf_pkg::GRP_X1;
                if (pressed_reg) begin
                    pressed_reg <= 1'b0;
                end else begin
                    start_x_reg <= '0;
                    start_y_reg <= '0;
                    held_x_reg  <= rtsf_pkg::COORD_NONE;
                    held_y_reg  <= rtsf_pkg::COORD_NONE;
                end
            end
            if (cmd.ack) begin
                ok_reg     <= 1'b0;
                caught_reg <= 1'b0;
            end
            if (cmd.update) begin
                if (!pressed_reg) begin
                    pressed_reg <= 1'b1;
                    caught_reg  <= 1'b1;
                    start_x_reg <= hx_new;
                    start_y_reg <= hy_new;
                end
                if (cfg.landscape) begin
                    held_x_reg <= cfg.screen_width - hy_new;
                    held_y_reg <= hx_new;
                end else begin
                    held_x_reg <= hx_new;
                    held_y_reg <= hy_new;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_x_coord_reg    <= held_x_reg;
            m_y_coord_reg    <= held_y_reg;
            m_reading_ok_reg <= ok_reg;
            m_pressed_reg    <= pressed_reg;
            m_caught_reg     <= caught_reg;
            m_start_x_reg    <= start_x_reg;
            m_start_y_reg    <= start_y_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_x_coord    = m_x_coord_reg;
    assign m_y_coord    = m_y_coord_reg;
    assign m_reading_ok = m_reading_ok_reg;
    assign m_pressed    = m_pressed_reg;
    assign m_caught     = m_caught_reg;
    assign m_start_x    = m_start_x_reg;
    assign m_start_y    = m_start_y_reg;

    assign sts.group_full = (pos_reg == POS_LAST);
    assign sts.last_group = (grp_reg == rtsf_pkg::GRP_Y2);
    assign sts.out_free   = !m_valid_reg || m_ready;

endmodule
